### rtl/core/dsm_pkg.sv
// Shared types and constants for the DFA state minimizer.
// Field widths, opcodes, register indexes, controller states and
// the command/status structs between controller and datapath.
package dsm_pkg;

	localparam int STATE_W = 4;
	localparam int SYM_W   = 3;
	localparam int MASK_W  = 16;
	localparam int CFG_W   = 5;
	localparam int NSYM_W  = 4;
	localparam int CIDX_W  = 1;

	typedef enum logic [1:0] {
		OP_SET_FINAL = 2'd0,
		OP_SET_TRANS = 2'd1,
		OP_RUN       = 2'd2
	} op_t;

	typedef enum logic [CIDX_W-1:0] {
		CFG_NUM_STATES  = 1'b0,
		CFG_NUM_SYMBOLS = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_PASS,
		ST_PAIR,
		ST_READ,
		ST_EVAL,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load_flag;
		logic load_trans;
		logic init_table;
		logic clr_changed;
		logic rst_pair;
		logic adv_pair;
		logic rst_sym;
		logic adv_sym;
		logic rd_trans;
		logic mark;
		logic rst_row;
		logic emit_row;
	} cmd_t;

	typedef struct packed {
		logic pair_marked;
		logic split;
		logic sym_last;
		logic no_syms;
		logic pair_last;
		logic no_pairs;
		logic changed;
		logic row_last;
		logic out_free;
	} sts_t;

endpackage

### rtl/core/dsm_if.sv
// Valid/ready channel interfaces of the DFA state minimizer.
// Depends on dsm_pkg for the field widths.
interface dsm_item_if;
	import dsm_pkg::*;
	logic               valid;
	logic               ready;
	logic [1:0]         opcode;
	logic [STATE_W-1:0] state_index;
	logic [SYM_W-1:0]   symbol_index;
	logic [STATE_W-1:0] target_state;
	logic               final_flag;

	modport source (output valid, opcode, state_index, symbol_index, target_state,
		final_flag, input ready);
	modport sink (input valid, opcode, state_index, symbol_index, target_state,
		final_flag, output ready);
endinterface

interface dsm_row_if;
	import dsm_pkg::*;
	logic               valid;
	logic               ready;
	logic [STATE_W-1:0] row_state;
	logic [MASK_W-1:0]  equivalent_mask;
	logic               last;

	modport source (output valid, row_state, equivalent_mask, last, input ready);
	modport sink (input valid, row_state, equivalent_mask, last, output ready);
endinterface

### rtl/core/dsm_ctrl.sv
// Controller FSM of the DFA state minimizer: load decode, pass/pair/symbol
// sequencing and row emission. Depends on dsm_pkg.
module dsm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	input  logic [1:0]    opcode,
	output logic          item_ready,
	input  dsm_pkg::sts_t sts,
	output dsm_pkg::cmd_t cmd
);
	import dsm_pkg::*;

	state_t state_q, state_nx, after_pair;
	logic   marking;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	assign marking = (state_q == ST_EVAL) && sts.split;

	always_comb begin
		after_pair = ST_PAIR;
		if (sts.pair_last) begin
			after_pair = (sts.changed || marking) ? ST_PASS : ST_EMIT;
		end
	end

	always_comb begin
		state_nx   = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					unique case (opcode)
						OP_SET_FINAL: cmd.load_flag  = 1'b1;
						OP_SET_TRANS: cmd.load_trans = 1'b1;
						OP_RUN:       state_nx       = ST_INIT;
						default:      ;
					endcase
				end
			end
			ST_INIT: begin
				cmd.init_table = 1'b1;
				state_nx       = ST_PASS;
			end
			ST_PASS: begin
				cmd.clr_changed = 1'b1;
				cmd.rst_pair    = 1'b1;
				cmd.rst_row     = 1'b1;
				state_nx        = sts.no_pairs ? ST_EMIT : ST_PAIR;
			end
			ST_PAIR: begin
				cmd.rst_sym = 1'b1;
				if (sts.pair_marked || sts.no_syms) begin
					cmd.adv_pair = 1'b1;
					state_nx     = after_pair;
				end else begin
					state_nx = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd_trans = 1'b1;
				state_nx     = ST_EVAL;
			end
			ST_EVAL: begin
				if (sts.split) begin
					cmd.mark     = 1'b1;
					cmd.adv_pair = 1'b1;
					state_nx     = after_pair;
				end else if (sts.sym_last) begin
					cmd.adv_pair = 1'b1;
					state_nx     = after_pair;
				end else begin
					cmd.adv_sym = 1'b1;
					state_nx    = ST_READ;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_row = 1'b1;
					if (sts.row_last) begin
						state_nx = ST_IDLE;
					end
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	a_eval_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EVAL |-> $past(state_q) == ST_READ)
		else $error("evaluation without a preceding transition read");

	a_emit_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_row && sts.row_last |=> state_q == ST_IDLE)
		else $error("run did not end after its final row");

	a_pass_restart_needs_mark: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PASS && $past(state_q) != ST_INIT |-> $past(sts.changed || marking))
		else $error("new pass started after a pass that marked nothing");

endmodule

### rtl/core/dsm_dpath.sv
// Datapath of the DFA state minimizer: config registers, accepting flags,
// transition memory, distinguishability table, counters, output register.
// Depends on dsm_pkg and dsm_if; driven by dsm_ctrl through cmd_t.
module dsm_dpath #(
	parameter int MAX_STATES  = 16,
	parameter int MAX_SYMBOLS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [dsm_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [dsm_pkg::CFG_W-1:0]    cfg_wdata,
	input  logic [dsm_pkg::STATE_W-1:0]  state_index,
	input  logic [dsm_pkg::SYM_W-1:0]    symbol_index,
	input  logic [dsm_pkg::STATE_W-1:0]  target_state,
	input  logic                         final_flag,
	input  dsm_pkg::cmd_t                cmd,
	output dsm_pkg::sts_t                sts,
	dsm_row_if.source                    rows
);
	import dsm_pkg::*;

	localparam int SW    = $clog2(MAX_STATES);
	localparam int YW    = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
	localparam int MW    = $clog2(MAX_SYMBOLS + 1);
	localparam int AW    = SW + YW;
	localparam int DEPTH = 1 << AW;
	localparam int CW    = (SW > STATE_W) ? SW : STATE_W;

	logic [CFG_W-1:0]      num_states_q;
	logic [NSYM_W-1:0]     num_symbols_q;
	logic [MAX_STATES-1:0] flags_q;
	logic [DEPTH-1:0]      present_q;
	logic [STATE_W-1:0]    trans_mem [DEPTH];
	logic [MAX_STATES-1:0] dist_q [MAX_STATES];
	logic [SW-1:0]         i_q, j_q, r_q;
	logic [YW-1:0]         c_q;
	logic [STATE_W-1:0]    ta_q, tb_q;
	logic                  pa_raw_q, pb_raw_q;
	logic                  changed_q;
	logic                  out_valid_q;
	logic [STATE_W-1:0]    row_q;
	logic [MASK_W-1:0]     mask_q;
	logic                  last_q;

	logic [SW-1:0]         n_m1, rows_m1;
	logic [MW-1:0]         m_eff;
	logic                  load_ok, trans_ok;
	logic [AW-1:0]         wr_addr;
	logic                  pa, pb, succ_marked;
	logic [MASK_W-1:0]     mask;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_states_q  <= CFG_W'(1);
			num_symbols_q <= NSYM_W'(2);
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_NUM_STATES:  num_states_q  <= cfg_wdata;
				CFG_NUM_SYMBOLS: num_symbols_q <= cfg_wdata[NSYM_W-1:0];
				default:         ;
			endcase
		end
	end

	always_comb begin
		if (num_states_q == '0) begin
			n_m1 = '0;
		end else if (32'(num_states_q) > MAX_STATES) begin
			n_m1 = SW'(MAX_STATES - 1);
		end else begin
			n_m1 = SW'(num_states_q - CFG_W'(1));
		end
		if (32'(n_m1) > MASK_W - 1) begin
			rows_m1 = SW'(MASK_W - 1);
		end else begin
			rows_m1 = n_m1;
		end
		if (32'(num_symbols_q) > MAX_SYMBOLS) begin
			m_eff = MW'(MAX_SYMBOLS);
		end else begin
			m_eff = MW'(num_symbols_q);
		end
	end

	// loading
	assign load_ok  = 32'(state_index) < MAX_STATES;
	assign trans_ok = load_ok && (32'(symbol_index) < MAX_SYMBOLS);
	assign wr_addr  = {SW'(state_index), YW'(symbol_index)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q   <= '0;
			present_q <= '0;
		end else begin
			if (cmd.load_flag && load_ok) begin
				flags_q[SW'(state_index)] <= final_flag;
			end
			if (cmd.load_trans && trans_ok) begin
				present_q[wr_addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_trans && trans_ok) begin
			trans_mem[wr_addr] <= target_state;
		end
		if (cmd.rd_trans) begin
			ta_q     <= trans_mem[{i_q, c_q}];
			tb_q     <= trans_mem[{j_q, c_q}];
			pa_raw_q <= present_q[{i_q, c_q}];
			pb_raw_q <= present_q[{j_q, c_q}];
		end
	end

	// pair evaluation on one symbol
	assign pa          = pa_raw_q && (CW'(ta_q) <= CW'(n_m1));
	assign pb          = pb_raw_q && (CW'(tb_q) <= CW'(n_m1));
	assign succ_marked = dist_q[SW'(ta_q)][SW'(tb_q)];

	// distinguishability table
	always_ff @(posedge clk) begin
		if (cmd.init_table) begin
			for (int a = 0; a < MAX_STATES; a++) begin
				for (int b = 0; b < MAX_STATES; b++) begin
					dist_q[a][b] <= flags_q[a] ^ flags_q[b];
				end
			end
		end else if (cmd.mark) begin
			dist_q[i_q][j_q] <= 1'b1;
			dist_q[j_q][i_q] <= 1'b1;
		end
	end

	// counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q       <= '0;
			j_q       <= '0;
			c_q       <= '0;
			r_q       <= '0;
			changed_q <= 1'b0;
		end else begin
			if (cmd.rst_pair) begin
				i_q <= '0;
				j_q <= SW'(1);
			end else if (cmd.adv_pair) begin
				if (j_q == n_m1) begin
					i_q <= i_q + SW'(1);
					j_q <= i_q + SW'(2);
				end else begin
					j_q <= j_q + SW'(1);
				end
			end
			if (cmd.rst_sym) begin
				c_q <= '0;
			end else if (cmd.adv_sym) begin
				c_q <= c_q + YW'(1);
			end
			if (cmd.rst_row) begin
				r_q <= '0;
			end else if (cmd.emit_row) begin
				r_q <= r_q + SW'(1);
			end
			if (cmd.clr_changed) begin
				changed_q <= 1'b0;
			end else if (cmd.mark) begin
				changed_q <= 1'b1;
			end
		end
	end

	// row mask
	always_comb begin
		for (int k = 0; k < MASK_W; k++) begin
			mask[k] = 1'b0;
			if (k < MAX_STATES) begin
				if (32'(r_q) < k && k <= 32'(n_m1)) begin
					mask[k] = !dist_q[r_q][SW'(k)];
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_row) begin
			out_valid_q <= 1'b1;
		end else if (rows.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_row) begin
			row_q  <= STATE_W'(r_q);
			mask_q <= mask;
			last_q <= (r_q == rows_m1);
		end
	end

	assign rows.valid           = out_valid_q;
	assign rows.row_state       = row_q;
	assign rows.equivalent_mask = mask_q;
	assign rows.last            = last_q;

	assign sts.pair_marked = dist_q[i_q][j_q];
	assign sts.split       = (pa != pb) || (pa && pb && (ta_q != tb_q) && succ_marked);
	assign sts.sym_last    = (MW'(c_q) + MW'(1)) == m_eff;
	assign sts.no_syms     = (m_eff == '0);
	assign sts.pair_last   = (j_q == n_m1) && (i_q == n_m1 - SW'(1));
	assign sts.no_pairs    = (n_m1 == '0);
	assign sts.changed     = changed_q;
	assign sts.row_last    = (r_q == rows_m1);
	assign sts.out_free    = !out_valid_q || rows.ready;

	a_mark_fresh_pair: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mark |-> !dist_q[i_q][j_q] && (i_q < j_q))
		else $error("marking a pair that is already marked or misordered");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_trans |-> (i_q < j_q) && (j_q <= n_m1))
		else $error("transition read for a pair outside the states in use");

	a_no_row_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_row |-> !out_valid_q || rows.ready)
		else $error("row register overwritten before it was taken");

	a_mark_sets_changed: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mark && !cmd.clr_changed |=> changed_q)
		else $error("mark did not raise the pass change flag");

endmodule

### rtl/core/dfa_state_minimizer.sv
// DFA state minimizer, table-filling method. Load items (final flag or
// transition) are taken one per cycle while idle and produce nothing. A run item
// occupies the block, which then accepts no item until its last row has
// entered the output register: the table is first seeded from the accepting
// flags, then repeated passes run over all state pairs of the states in use,
// each pass having a restart step, a step for every pair and, for each symbol
// examined on an unmarked pair, a transition memory read, then evaluation
// in the single shared pair evaluator. Passes repeat until one marks nothing,
// so a run takes at most n(n-1)/2 + 1 passes. One row per state in use (at
// most 16) then leaves through the output register, one per cycle when not
// stalled.
// Depends on dsm_pkg, dsm_if, dsm_ctrl and dsm_dpath.
module dfa_state_minimizer #(
	parameter int MAX_STATES  = 16,
	parameter int MAX_SYMBOLS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [dsm_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [dsm_pkg::CFG_W-1:0]   cfg_wdata,
	dsm_item_if.sink                    items,
	dsm_row_if.source                   rows
);
	import dsm_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic item_ready;

	assign items.ready = item_ready;

	dsm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (items.valid),
		.opcode     (items.opcode),
		.item_ready (item_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	dsm_dpath #(
		.MAX_STATES  (MAX_STATES),
		.MAX_SYMBOLS (MAX_SYMBOLS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.state_index  (items.state_index),
		.symbol_index (items.symbol_index),
		.target_state (items.target_state),
		.final_flag   (items.final_flag),
		.cmd          (cmd),
		.sts          (sts),
		.rows         (rows)
	);

endmodule
